// File: src/command_line_tokenizer_macros.svh
// ----------------------------------------------------------------------------
// Command line tokenizer assertion macros
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef COMMAND_LINE_TOKENIZER_MACROS_SVH
`define COMMAND_LINE_TOKENIZER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CLTOK_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("cltok: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CLTOK_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("cltok: next-cycle check failed");

`endif

// File: src/cltok_pkg.sv
// ----------------------------------------------------------------------------
// Command line tokenizer package
// Result kinds, lexer modes, character constants and shared structs.
// ----------------------------------------------------------------------------
package cltok_pkg;

  // Most results one input byte can cause
  localparam int unsigned MaxResults = 3;

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_EOT  = 2'd1,
    KIND_EOS  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    MODE_GAP   = 3'd0,
    MODE_WORD  = 3'd1,
    MODE_QUOTE = 3'd2,
    MODE_LINE  = 3'd3,
    MODE_BLOCK = 3'd4,
    MODE_BSTAR = 3'd5
  } mode_e;

  localparam logic [7:0] ChNul   = 8'd0;
  localparam logic [7:0] ChSpace = 8'd32;
  localparam logic [7:0] ChQuote = 8'd34;
  localparam logic [7:0] ChStar  = 8'd42;
  localparam logic [7:0] ChSlash = 8'd47;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] chr;
  } result_t;

  // Results of one byte, slot 0 first
  typedef struct packed {
    logic [1:0]                   cnt;
    result_t [MaxResults-1:0]     res;
  } lex_out_t;

  localparam result_t ResEot = '{kind: KIND_EOT, chr: 8'h00};
  localparam result_t ResEos = '{kind: KIND_EOS, chr: 8'h00};

endpackage

// File: src/cltok_lexer.sv
// ----------------------------------------------------------------------------
// Command line tokenizer lexer
// Holds the lexer mode and held-slash flag and decodes one byte into up to
// three results; state advances when the byte leaves the input register.
// ----------------------------------------------------------------------------
module cltok_lexer
  import cltok_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       adv_i,
  input  logic [7:0] in_byte_i,
  output lex_out_t   lex_o
);

  mode_e      mode_q, mode_d;
  logic       slash_q, slash_d;
  logic [1:0] n;
  logic       after_sl, in_word, use_word, use_gap, is_space;

  assign is_space = in_byte_i inside {[8'd1:ChSpace], [8'd128:8'd255]};

  // Byte decode
  always_comb begin
    mode_d   = mode_q;
    slash_d  = slash_q;
    lex_o    = '0;
    n        = 2'd0;
    after_sl = 1'b0;
    in_word  = 1'b0;
    use_word = 1'b0;
    use_gap  = 1'b0;

    case (mode_q)
      MODE_WORD: begin
        if (slash_q) begin
          after_sl = 1'b1;
          in_word  = 1'b1;
        end else begin
          use_word = 1'b1;
        end
      end
      MODE_QUOTE: begin
        slash_d = 1'b0;
        if (in_byte_i == ChNul) begin
          lex_o.res[n] = ResEot;
          n = n + 2'd1;
          lex_o.res[n] = ResEos;
          n = n + 2'd1;
          mode_d = MODE_GAP;
        end else if (in_byte_i == ChQuote) begin
          lex_o.res[n] = ResEot;
          n = n + 2'd1;
          mode_d = MODE_GAP;
        end else begin
          lex_o.res[n] = '{kind: KIND_BYTE, chr: in_byte_i};
          n = n + 2'd1;
        end
      end
      MODE_LINE: begin
        slash_d = 1'b0;
        if (in_byte_i == ChNul) begin
          lex_o.res[n] = ResEos;
          n = n + 2'd1;
          mode_d = MODE_GAP;
        end
      end
      MODE_BLOCK: begin
        slash_d = 1'b0;
        if (in_byte_i == ChNul) begin
          lex_o.res[n] = ResEos;
          n = n + 2'd1;
          mode_d = MODE_GAP;
        end else if (in_byte_i == ChStar) begin
          mode_d = MODE_BSTAR;
        end
      end
      MODE_BSTAR: begin
        slash_d = 1'b0;
        if (in_byte_i == ChNul) begin
          lex_o.res[n] = ResEos;
          n = n + 2'd1;
          mode_d = MODE_GAP;
        end else if (in_byte_i == ChSlash) begin
          mode_d = MODE_GAP;
        end else if (in_byte_i != ChStar) begin
          mode_d = MODE_BLOCK;
        end
      end
      default: begin
        // gap, and the unused codes that act as the gap
        mode_d = MODE_GAP;
        if (slash_q) begin
          after_sl = 1'b1;
        end else begin
          use_gap = 1'b1;
        end
      end
    endcase

    // Byte after a held slash: comment opener or a lone slash
    if (after_sl) begin
      slash_d = 1'b0;
      if (in_byte_i == ChSlash || in_byte_i == ChStar) begin
        if (in_word) begin
          lex_o.res[n] = ResEot;
          n = n + 2'd1;
        end
        mode_d = (in_byte_i == ChSlash) ? MODE_LINE : MODE_BSTAR;
      end else begin
        lex_o.res[n] = '{kind: KIND_BYTE, chr: ChSlash};
        n = n + 2'd1;
        use_word = 1'b1;
      end
    end

    // Byte inside a plain token
    if (use_word) begin
      if (in_byte_i == ChNul) begin
        lex_o.res[n] = ResEot;
        n = n + 2'd1;
        lex_o.res[n] = ResEos;
        n = n + 2'd1;
        mode_d  = MODE_GAP;
        slash_d = 1'b0;
      end else if (is_space) begin
        lex_o.res[n] = ResEot;
        n = n + 2'd1;
        mode_d = MODE_GAP;
      end else if (in_byte_i == ChQuote) begin
        lex_o.res[n] = ResEot;
        n = n + 2'd1;
        mode_d = MODE_QUOTE;
      end else if (in_byte_i == ChSlash) begin
        slash_d = 1'b1;
        mode_d  = MODE_WORD;
      end else begin
        lex_o.res[n] = '{kind: KIND_BYTE, chr: in_byte_i};
        n = n + 2'd1;
        mode_d = MODE_WORD;
      end
    end

    // Byte between tokens
    if (use_gap) begin
      if (in_byte_i == ChNul) begin
        lex_o.res[n] = ResEos;
        n = n + 2'd1;
        mode_d  = MODE_GAP;
        slash_d = 1'b0;
      end else if (is_space) begin
        mode_d = MODE_GAP;
      end else if (in_byte_i == ChQuote) begin
        mode_d = MODE_QUOTE;
      end else if (in_byte_i == ChSlash) begin
        slash_d = 1'b1;
        mode_d  = MODE_GAP;
      end else begin
        lex_o.res[n] = '{kind: KIND_BYTE, chr: in_byte_i};
        n = n + 2'd1;
        mode_d = MODE_WORD;
      end
    end

    lex_o.cnt = n;
  end

  // Lexer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_GAP;
      slash_q <= 1'b0;
    end else if (adv_i) begin
      mode_q  <= mode_d;
      slash_q <= slash_d;
    end
  end

endmodule

// File: src/cltok_result_buf.sv
// ----------------------------------------------------------------------------
// Command line tokenizer result buffer
// Registers the results of one byte and hands them out one per transaction,
// marking the last one.
// ----------------------------------------------------------------------------
module cltok_result_buf
  import cltok_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  lex_out_t   lex_i,
  output logic       free_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] out_kind_o,
  output logic [7:0] out_byte_o,
  output logic       run_last_o
);

  logic                     vld_q, vld_d;
  logic [1:0]               cnt_q, cnt_d;
  logic [1:0]               idx_q, idx_d;
  result_t [MaxResults-1:0] res_q;
  result_t                  cur;
  logic                     take, last;

  assign take   = vld_q & out_ready_i;
  assign last   = (idx_q == (cnt_q - 2'd1));
  assign free_o = ~vld_q | (take & last);

  // Current slot
  always_comb begin
    case (idx_q)
      2'd1:    cur = res_q[1];
      2'd2:    cur = res_q[2];
      default: cur = res_q[0];
    endcase
  end

  assign out_valid_o = vld_q;
  assign out_kind_o  = cur.kind;
  assign out_byte_o  = cur.chr;
  assign run_last_o  = last;

  // Slot sequencing
  always_comb begin
    vld_d = vld_q;
    cnt_d = cnt_q;
    idx_d = idx_q;
    if (take) begin
      if (last) begin
        vld_d = 1'b0;
      end else begin
        idx_d = idx_q + 2'd1;
      end
    end
    if (load_i) begin
      vld_d = 1'b1;
      cnt_d = lex_i.cnt;
      idx_d = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      cnt_q <= 2'd1;
      idx_q <= 2'd0;
    end else begin
      vld_q <= vld_d;
      cnt_q <= cnt_d;
      idx_q <= idx_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= lex_i.res;
    end
  end

endmodule

// File: src/command_line_tokenizer.sv
// ----------------------------------------------------------------------------
// Command line tokenizer
// Splits a byte stream into token bytes, end-of-token and end-of-string
// marks, with quoted tokens and line and block comments.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) takes one byte per transaction;
//   a zero byte ends the string. Output channel (out_valid_o / out_ready_i)
//   gives one result per transaction: out_kind_o is 0 for a token byte in
//   out_byte_o, 1 for end of token, 2 for end of string. run_last_o marks
//   the last result caused by one input byte; a byte may cause none.
//   Path: an accepted byte passes the input register, then the result
//   register, before its first result shows.
//   Throughput: one byte per cycle while each byte causes at most one
//   result and out_ready_i is high; a byte with k results holds the single
//   result register while it drains one slot per transaction.
//   Reset: lexer returns to the gap between tokens with no held slash,
//   both registers empty.
//   Stall: when out_ready_i is low the result holds; the input register
//   still takes one more byte, then in_ready_o drops until space frees.
// ----------------------------------------------------------------------------
module command_line_tokenizer
  import cltok_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] out_kind_o,
  output logic [7:0] out_byte_o,
  output logic       run_last_o
);

  logic       in_vld_q, in_vld_d;
  logic [7:0] in_byte_q;
  logic       res_free, adv, accept;
  lex_out_t   lex;

  assign adv        = in_vld_q & res_free;
  assign in_ready_o = ~in_vld_q | adv;
  assign accept     = in_valid_i & in_ready_o;

  // Input register
  always_comb begin
    in_vld_d = in_vld_q;
    if (in_ready_o) begin
      in_vld_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_byte_q <= in_byte_i;
    end
  end

  // Decode
  cltok_lexer u_lexer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .in_byte_i (in_byte_q),
    .lex_o     (lex)
  );

  // Result register and serializer
  cltok_result_buf u_result_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (adv && (lex.cnt != 2'd0)),
    .lex_i       (lex),
    .free_o      (res_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_kind_o  (out_kind_o),
    .out_byte_o  (out_byte_o),
    .run_last_o  (run_last_o)
  );

endmodule

// File: src/cltok_checker.sv
// ----------------------------------------------------------------------------
// Command line tokenizer port checker
// Watches the top level ports for result formatting and sequencing.
// ----------------------------------------------------------------------------
`include "command_line_tokenizer_macros.svh"

module cltok_checker
  import cltok_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [1:0] out_kind_o,
  input logic [7:0] out_byte_o,
  input logic       run_last_o
);

  logic        out_mark, out_eos, out_more, out_stall;
  logic [10:0] out_word;

  // Output channel conditions
  assign out_mark  = out_valid_o && (out_kind_o != KIND_BYTE);
  assign out_eos   = out_valid_o && (out_kind_o == KIND_EOS);
  assign out_more  = out_valid_o && out_ready_i && !run_last_o;
  assign out_stall = out_valid_o && !out_ready_i;
  assign out_word  = {out_kind_o, out_byte_o, run_last_o};

  // Marks carry no character
  `CLTOK_ASSERT_IMPLY(a_mark_byte_zero, clk_i, rst_ni, out_mark, out_byte_o == 8'h00)

  // End of string is always the last result of its byte
  `CLTOK_ASSERT_IMPLY(a_eos_last, clk_i, rst_ni, out_eos, run_last_o)

  // Remaining results of a byte follow without a gap
  `CLTOK_ASSERT_NEXT(a_run_contig, clk_i, rst_ni, out_more, out_valid_o)

  // Stalled transaction holds
  `CLTOK_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_o && $stable(out_word))

endmodule

bind command_line_tokenizer cltok_checker u_cltok_checker (.*);
